// File: rtl/core/event_notify_unit_macros.svh
// assertion macros for the event notification unit
`ifndef EVENT_NOTIFY_UNIT_MACROS_SVH
`define EVENT_NOTIFY_UNIT_MACROS_SVH
// check a property on every clock edge out of reset
`define ENU_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");
// check that a cause is followed by an effect in the next cycle
`define ENU_ASSERT_NEXT(label, clk, rst_n, cause, effect) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cause) |=> (effect)) \
    else $error("assertion failed");
`endif

// File: rtl/core/enu_pkg.sv
// package: types, codes and defaults for the event notification unit
package enu_pkg;
  localparam int SLOTS_DEF = 16;
  localparam int WAITERS_DEF = 16;

  typedef enum logic [3:0] {
    K_CREATE = 4'd0, K_CLOSE = 4'd1, K_NOTIFY_ONE = 4'd2, K_NOTIFY_ALL = 4'd3,
    K_WAIT_BEGIN = 4'd4, K_POLL = 4'd5, K_CANCEL = 4'd6, K_COUNT = 4'd7,
    K_RESET_ALL = 4'd8
  } kind_t;

  typedef enum logic [2:0] {
    ST_OK = 3'd0, ST_INVALID_ARGUMENT = 3'd1, ST_EXHAUSTED = 3'd2, ST_STALE = 3'd3,
    ST_DISCONNECTED = 3'd4, ST_INVALID_STATE = 3'd5, ST_PENDING = 3'd6,
    ST_CANCELLED = 3'd7
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE, S_READ, S_EXEC, S_CREATE_SCAN, S_CREATE_RD, S_RESET_RD, S_RESET_WR, S_OUT
  } fsm_t;

  function automatic logic [15:0] gen_step(input logic [15:0] g);
    logic [15:0] n;
    n = g + 16'd1;
    return (n == 16'd0) ? 16'd1 : n;
  endfunction
endpackage

// File: rtl/core/event_notify_unit.sv
// top level of the event notification unit
//   channel | direction | handshake
//   in_     | input     | in_valid / in_stall
//   out_    | output    | out_valid / out_stall
// each word runs through a sequencer: read slot entry, execute, write back, present
// simple requests pass through the read, execute and output states; create scans the
// slots in turn from slot zero to the first free one; reset_all rewrites each slot below hwm
// slot memory contents are held across reset: a generation counter is valid only
// once its slot has been touched (per-slot touched flags reset to zero)
// a stalled output holds its word and no new word is taken until it leaves
module event_notify_unit #(
  parameter int SLOTS = enu_pkg::SLOTS_DEF,
  parameter int WAITERS = enu_pkg::WAITERS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [3:0]  in_kind,
  input  logic [7:0]  in_slot_index,
  input  logic [15:0] in_handle_generation,
  input  logic [7:0]  in_waiter_index,
  input  logic        in_cancelled,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  out_status,
  output logic [3:0]  out_out_slot,
  output logic [15:0] out_out_generation,
  output logic [3:0]  out_out_waiter,
  output logic [4:0]  out_waiter_total
);
  import enu_pkg::*;
  localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int WW = (WAITERS > 1) ? $clog2(WAITERS) : 1;
  localparam int CW = $clog2(WAITERS + 1);
  localparam int HW = $clog2(SLOTS + 1);
  localparam int DW = 16 + CW + 2 * WAITERS;

  fsm_t state_r, state_nxt;
  logic [3:0]  kind_r;
  logic [7:0]  slot_r;
  logic [15:0] gen_r;
  logic [7:0]  widx_r;
  logic        canc_r;
  logic [SLOTS-1:0] alive_r, alive_nxt, touched_r, touched_nxt;
  logic [HW-1:0] hwm_r, hwm_nxt;
  logic [SW-1:0] ptr_r, ptr_nxt;
  logic [2:0]  st_r, st_nxt;
  logic [3:0]  oslot_r, oslot_nxt, owait_r, owait_nxt;
  logic [15:0] ogen_r, ogen_nxt;
  logic [4:0]  otot_r, otot_nxt;

  logic          wr_en;
  logic [SW-1:0] wr_addr, rd_addr;
  logic [DW-1:0] wr_data, rd_data;

  enu_slot_mem #(.SLOTS(SLOTS), .WAITERS(WAITERS)) u_mem (
    .clk(clk), .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(wr_data),
    .rd_addr(rd_addr), .rd_data(rd_data)
  );

  // unpack the slot entry; untouched slots read as zero
  logic [15:0] m_gen;
  logic [CW-1:0] m_cnt;
  logic [WAITERS-1:0] m_act, m_ntf;
  logic [SW-1:0] sidx;
  always_comb begin
    sidx = slot_r[SW-1:0];
    if (touched_r[ptr_r]) begin
      {m_gen, m_cnt, m_act, m_ntf} = rd_data;
    end else begin
      {m_gen, m_cnt, m_act, m_ntf} = '0;
    end
  end

  // priority picks: lowest free waiter, lowest pending waiter
  logic [WW-1:0] free_w, pend_w;
  logic free_any, pend_any;
  always_comb begin
    free_w = '0; pend_w = '0; free_any = 1'b0; pend_any = 1'b0;
    for (int i = WAITERS - 1; i >= 0; i--) begin
      if (!m_act[i]) begin
        free_w = WW'(i); free_any = 1'b1;
      end
      if (m_act[i] && !m_ntf[i]) begin
        pend_w = WW'(i); pend_any = 1'b1;
      end
    end
  end

  logic slot_ok, live, widx_ok, wbit_act, wbit_ntf;
  logic [WAITERS-1:0] wmask;
  always_comb begin
    slot_ok = ({24'd0, slot_r} < 32'(SLOTS));
    widx_ok = ({24'd0, widx_r} < 32'(WAITERS));
    live = slot_ok && alive_r[sidx] && (m_gen == gen_r);
    wmask = '0;
    wbit_act = 1'b0; wbit_ntf = 1'b0;
    for (int i = 0; i < WAITERS; i++) begin
      if (widx_r == 8'(i)) begin
        wmask[i] = 1'b1;
        wbit_act = m_act[i];
        wbit_ntf = m_ntf[i];
      end
    end
  end

  // state register and request capture
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      alive_r <= '0;
      touched_r <= '0;
      hwm_r <= '0;
    end else begin
      state_r <= state_nxt;
      alive_r <= alive_nxt;
      touched_r <= touched_nxt;
      hwm_r <= hwm_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_IDLE && in_valid) begin
      kind_r <= in_kind;
      slot_r <= in_slot_index;
      gen_r <= in_handle_generation;
      widx_r <= in_waiter_index;
      canc_r <= in_cancelled;
    end
    ptr_r <= ptr_nxt;
    st_r <= st_nxt;
    oslot_r <= oslot_nxt;
    ogen_r <= ogen_nxt;
    owait_r <= owait_nxt;
    otot_r <= otot_nxt;
  end

  // sequencer: next state, memory access and result
  always_comb begin
    state_nxt = state_r;
    alive_nxt = alive_r;
    touched_nxt = touched_r;
    hwm_nxt = hwm_r;
    ptr_nxt = ptr_r;
    st_nxt = st_r; oslot_nxt = oslot_r; ogen_nxt = ogen_r;
    owait_nxt = owait_r; otot_nxt = otot_r;
    wr_en = 1'b0; wr_addr = ptr_r; wr_data = {m_gen, m_cnt, m_act, m_ntf};
    rd_addr = ptr_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = S_READ;
          ptr_nxt = in_slot_index[SW-1:0];
          rd_addr = in_slot_index[SW-1:0];
        end
      end
      S_READ: begin
        state_nxt = S_EXEC;
        st_nxt = ST_OK; oslot_nxt = '0; ogen_nxt = '0; owait_nxt = '0; otot_nxt = '0;
        if (kind_r == K_CREATE) begin
          state_nxt = S_CREATE_SCAN; ptr_nxt = '0;
        end else if (kind_r == K_RESET_ALL) begin
          ptr_nxt = '0;
          state_nxt = (hwm_r == '0) ? S_OUT : S_RESET_RD;
          if (hwm_r == '0) hwm_nxt = '0;
        end
      end
      S_EXEC: begin
        state_nxt = S_OUT;
        if (kind_r == K_COUNT) begin
          if (live) otot_nxt = 5'(m_cnt);
        end else if (kind_r > K_RESET_ALL || !slot_ok) begin
          st_nxt = ST_INVALID_ARGUMENT;
        end else if ((kind_r == K_POLL || kind_r == K_CANCEL) && !widx_ok) begin
          st_nxt = ST_INVALID_ARGUMENT;
        end else if (kind_r == K_POLL) begin
          if (!live) st_nxt = ST_DISCONNECTED;
          else if (!wbit_act) st_nxt = ST_INVALID_STATE;
          else if (canc_r || wbit_ntf) begin
            st_nxt = canc_r ? ST_CANCELLED : ST_OK;
            wr_en = 1'b1;
            wr_data = {m_gen, m_cnt - CW'(1), m_act & ~wmask, m_ntf & ~wmask};
          end else st_nxt = ST_PENDING;
        end else if (kind_r == K_CANCEL) begin
          if (live && wbit_act) begin
            wr_en = 1'b1;
            wr_data = {m_gen, m_cnt - CW'(1), m_act & ~wmask, m_ntf & ~wmask};
          end
        end else if (!live) begin
          st_nxt = ST_STALE;
        end else if (kind_r == K_CLOSE) begin
          alive_nxt[sidx] = 1'b0;
          wr_en = 1'b1;
          wr_data = {m_gen, CW'(0), {WAITERS{1'b0}}, {WAITERS{1'b0}}};
        end else if (kind_r == K_NOTIFY_ONE) begin
          if (pend_any) begin
            wr_en = 1'b1;
            wr_data = {m_gen, m_cnt, m_act, m_ntf | (WAITERS'(1) << pend_w)};
          end
        end else if (kind_r == K_NOTIFY_ALL) begin
          wr_en = 1'b1;
          wr_data = {m_gen, m_cnt, m_act, m_ntf | m_act};
        end else begin
          if (free_any) begin
            wr_en = 1'b1;
            wr_data = {m_gen, m_cnt + CW'(1), m_act | (WAITERS'(1) << free_w),
                       m_ntf & ~(WAITERS'(1) << free_w)};
            oslot_nxt = slot_r[3:0];
            ogen_nxt = gen_r;
            owait_nxt = 4'(free_w);
          end else st_nxt = ST_EXHAUSTED;
        end
      end
      S_CREATE_SCAN: begin
        // one slot per cycle; stop on the first free one
        if (!alive_r[ptr_r]) begin
          state_nxt = S_CREATE_RD;
        end else if (32'(ptr_r) == SLOTS - 1) begin
          st_nxt = ST_EXHAUSTED;
          state_nxt = S_OUT;
        end else begin
          ptr_nxt = ptr_r + SW'(1);
        end
      end
      S_CREATE_RD: begin
        state_nxt = S_OUT;
        wr_en = 1'b1;
        wr_data = {gen_step(m_gen), CW'(0), {WAITERS{1'b0}}, {WAITERS{1'b0}}};
        alive_nxt[ptr_r] = 1'b1;
        touched_nxt[ptr_r] = 1'b1;
        if (HW'(ptr_r) >= hwm_r) hwm_nxt = HW'(ptr_r) + HW'(1);
        oslot_nxt = 4'(ptr_r);
        ogen_nxt = gen_step(m_gen);
      end
      S_RESET_RD: begin
        state_nxt = S_RESET_WR;
      end
      S_RESET_WR: begin
        wr_en = 1'b1;
        wr_data = {gen_step(m_gen), CW'(0), {WAITERS{1'b0}}, {WAITERS{1'b0}}};
        alive_nxt[ptr_r] = 1'b0;
        touched_nxt[ptr_r] = 1'b1;
        if (HW'(ptr_r) + HW'(1) >= hwm_r) begin
          hwm_nxt = '0;
          state_nxt = S_OUT;
        end else begin
          ptr_nxt = ptr_r + SW'(1);
          state_nxt = S_RESET_RD;
        end
      end
      S_OUT: begin
        if (!out_stall) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign in_stall = (state_r != S_IDLE);
  assign out_valid = (state_r == S_OUT);
  assign out_status = st_r;
  assign out_out_slot = oslot_r;
  assign out_out_generation = ogen_r;
  assign out_out_waiter = owait_r;
  assign out_waiter_total = otot_r;

`include "event_notify_unit_macros.svh"
  `ENU_ASSERT_NEXT(a_one_word, clk, rst_n, in_valid && !in_stall, !out_valid)
  `ENU_ASSERT_NEXT(a_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_status))
  `ENU_ASSERT(a_hwm, clk, rst_n, (32'(hwm_r) <= SLOTS))
endmodule

// File: rtl/core/enu_slot_mem.sv
// slot memory: generation, waiter count, active and notified bits per slot
module enu_slot_mem #(
  parameter int SLOTS = enu_pkg::SLOTS_DEF,
  parameter int WAITERS = enu_pkg::WAITERS_DEF,
  localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1,
  localparam int CW = $clog2(WAITERS + 1),
  localparam int DW = 16 + CW + 2 * WAITERS
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [SW-1:0] wr_addr,
  input  logic [DW-1:0] wr_data,
  input  logic [SW-1:0] rd_addr,
  output logic [DW-1:0] rd_data
);
  import enu_pkg::*;
  logic [DW-1:0] mem [SLOTS];

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end
endmodule

// File: dv/tb_event_notify_unit.sv
// testbench for the event notification unit: directed and random requests checked against a predictor
module tb_event_notify_unit;
  import enu_pkg::*;

  localparam int NSLOT = SLOTS_DEF;
  localparam int NWAIT = WAITERS_DEF;
  localparam int CYCLE_LIMIT = 400000;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [3:0]  in_kind;
  logic [7:0]  in_slot_index;
  logic [15:0] in_handle_generation;
  logic [7:0]  in_waiter_index;
  logic        in_cancelled;
  logic        out_valid;
  logic        out_stall;
  logic [2:0]  out_status;
  logic [3:0]  out_out_slot;
  logic [15:0] out_out_generation;
  logic [3:0]  out_out_waiter;
  logic [4:0]  out_waiter_total;

  typedef struct packed {
    logic [2:0]  status;
    logic [3:0]  slot;
    logic [15:0] gen;
    logic [3:0]  waiter;
    logic [4:0]  total;
  } reply_t;

  // predictor state
  logic        alive_q [NSLOT];
  logic [15:0] gen_q [NSLOT];
  int          nwait_q [NSLOT];
  logic [NWAIT-1:0] active_q [NSLOT];
  logic [NWAIT-1:0] notified_q [NSLOT];
  int          hwm_q;

  reply_t replies_due [$];
  int errors;
  int words_sent;
  int words_checked;
  int cycles;
  int send_idle_pct;
  int recv_stall_pct;

  event_notify_unit i_dut (.*);

  // clock
  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // cycle limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("FAILURE");
      $finish;
    end
  end

  function automatic logic [15:0] bump_gen(logic [15:0] g);
    return (g == 16'hFFFF) ? 16'd1 : g + 16'd1;
  endfunction

  function automatic void wipe_slot(int s);
    alive_q[s] = 1'b0;
    nwait_q[s] = 0;
    active_q[s] = '0;
    notified_q[s] = '0;
  endfunction

  function automatic void drop_one(int s, int w);
    active_q[s][w] = 1'b0;
    notified_q[s][w] = 1'b0;
    if (nwait_q[s] > 0) nwait_q[s]--;
  endfunction

  // predicted reply for one request, with state update
  function automatic reply_t predict_reply(logic [3:0] k, logic [7:0] s, logic [15:0] g,
                                           logic [7:0] w, logic c);
    reply_t r;
    logic ok_slot;
    logic live;
    r = '0;
    r.status = ST_OK;
    ok_slot = s < NSLOT;
    live = ok_slot && alive_q[s] && gen_q[s] == g;
    if (k == K_CREATE) begin
      r.status = ST_EXHAUSTED;
      for (int i = 0; i < NSLOT; i++) begin
        if (!alive_q[i]) begin
          wipe_slot(i);
          alive_q[i] = 1'b1;
          gen_q[i] = bump_gen(gen_q[i]);
          if (i >= hwm_q) hwm_q = i + 1;
          r.status = ST_OK;
          r.slot = 4'(i);
          r.gen = gen_q[i];
          break;
        end
      end
    end else if (k == K_RESET_ALL) begin
      for (int i = 0; i < hwm_q && i < NSLOT; i++) begin
        gen_q[i] = bump_gen(gen_q[i]);
        wipe_slot(i);
      end
      hwm_q = 0;
    end else if (k == K_COUNT) begin
      if (live) r.total = 5'(nwait_q[s] > 31 ? 31 : nwait_q[s]);
    end else if (k > K_RESET_ALL || !ok_slot) begin
      r.status = ST_INVALID_ARGUMENT;
    end else if ((k == K_POLL || k == K_CANCEL) && w >= NWAIT) begin
      r.status = ST_INVALID_ARGUMENT;
    end else if (k == K_POLL) begin
      if (!live) r.status = ST_DISCONNECTED;
      else if (!active_q[s][w]) r.status = ST_INVALID_STATE;
      else if (c) begin
        drop_one(s, w);
        r.status = ST_CANCELLED;
      end else if (notified_q[s][w]) drop_one(s, w);
      else r.status = ST_PENDING;
    end else if (k == K_CANCEL) begin
      if (live && active_q[s][w]) drop_one(s, w);
    end else if (!live) begin
      r.status = ST_STALE;
    end else if (k == K_CLOSE) begin
      wipe_slot(s);
    end else if (k == K_NOTIFY_ONE) begin
      for (int i = 0; i < NWAIT; i++) begin
        if (active_q[s][i] && !notified_q[s][i]) begin
          notified_q[s][i] = 1'b1;
          break;
        end
      end
    end else if (k == K_NOTIFY_ALL) begin
      notified_q[s] = notified_q[s] | active_q[s];
    end else begin
      r.status = ST_EXHAUSTED;
      for (int i = 0; i < NWAIT; i++) begin
        if (!active_q[s][i]) begin
          active_q[s][i] = 1'b1;
          notified_q[s][i] = 1'b0;
          nwait_q[s]++;
          r.status = ST_OK;
          r.slot = s[3:0];
          r.gen = g;
          r.waiter = 4'(i);
          break;
        end
      end
    end
    return r;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    errors++;
    $display("mismatch word %0d %s: got %0d want %0d", words_checked, what, got, want);
  endtask

  // send one request word, with random idle gaps; valid stays up until the next word
  task automatic send_word(logic [3:0] k, logic [7:0] s, logic [15:0] g, logic [7:0] w,
                           logic c);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_kind <= k;
    in_slot_index <= s;
    in_handle_generation <= g;
    in_waiter_index <= w;
    in_cancelled <= c;
    replies_due.push_back(predict_reply(k, s, g, w, c));
    words_sent++;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // receiver stall
  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  // result checking
  always @(posedge clk) begin
    reply_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (replies_due.size() == 0) begin
        report_mismatch("unexpected word, status", 32'(out_status), 0);
      end else begin
        want = replies_due.pop_front();
        if (out_status !== want.status) report_mismatch("status", out_status, want.status);
        if (out_out_slot !== want.slot) report_mismatch("slot", out_out_slot, want.slot);
        if (out_out_generation !== want.gen)
          report_mismatch("generation", out_out_generation, want.gen);
        if (out_out_waiter !== want.waiter)
          report_mismatch("waiter", out_out_waiter, want.waiter);
        if (out_waiter_total !== want.total)
          report_mismatch("total", out_waiter_total, want.total);
      end
      words_checked++;
    end
  end

  task automatic drain;
    in_valid <= 1'b0;
    while (replies_due.size() != 0) @(posedge clk);
    repeat (80) @(posedge clk);
  endtask

  function automatic logic [15:0] gen_of(int s);
    return gen_q[s];
  endfunction

  // directed: every kind, stale handles, full tables, out-of-range fields
  task automatic test_directed;
    send_word(K_COUNT, 8'd0, 16'd0, 8'd0, 1'b0);
    send_word(K_CLOSE, 8'd0, 16'd0, 8'd0, 1'b0);
    send_word(K_POLL, 8'd0, 16'd0, 8'd0, 1'b0);
    send_word(K_CREATE, 8'hFF, 16'hFFFF, 8'hFF, 1'b1);
    send_word(K_WAIT_BEGIN, 8'd0, gen_of(0), 8'd0, 1'b0);
    send_word(K_WAIT_BEGIN, 8'd0, gen_of(0), 8'd0, 1'b0);
    send_word(K_POLL, 8'd0, gen_of(0), 8'd0, 1'b0);
    send_word(K_NOTIFY_ONE, 8'd0, gen_of(0), 8'd0, 1'b0);
    send_word(K_POLL, 8'd0, gen_of(0), 8'd0, 1'b0);
    send_word(K_POLL, 8'd0, gen_of(0), 8'd0, 1'b0);
    send_word(K_NOTIFY_ALL, 8'd0, gen_of(0), 8'd0, 1'b0);
    send_word(K_POLL, 8'd0, gen_of(0), 8'd1, 1'b1);
    send_word(K_POLL, 8'd0, gen_of(0), 8'hFF, 1'b0);
    send_word(K_CANCEL, 8'd0, gen_of(0), 8'd16, 1'b0);
    send_word(K_NOTIFY_ONE, 8'd0, 16'hFFFF, 8'd0, 1'b0);
    send_word(K_COUNT, 8'hFF, 16'd0, 8'd0, 1'b0);
    send_word(K_CLOSE, 8'd16, 16'd1, 8'd0, 1'b0);
    send_word(4'd9, 8'd0, 16'd0, 8'd0, 1'b0);
    send_word(4'd15, 8'd0, 16'd0, 8'd0, 1'b0);
    for (int i = 0; i < NWAIT + 1; i++) send_word(K_WAIT_BEGIN, 8'd0, gen_of(0), 8'd0, 1'b0);
    send_word(K_COUNT, 8'd0, gen_of(0), 8'd0, 1'b0);
    for (int i = 0; i < NSLOT + 1; i++) send_word(K_CREATE, 8'd0, 16'd0, 8'd0, 1'b0);
    send_word(K_RESET_ALL, 8'd0, 16'd0, 8'd0, 1'b0);
    send_word(K_CANCEL, 8'd0, 16'd1, 8'd0, 1'b0);
    drain();
  endtask

  // random: mostly well-formed handles, some noise
  task automatic test_random(int n);
    logic [3:0] k;
    logic [7:0] s;
    logic [15:0] g;
    logic [7:0] w;
    int pick;
    for (int i = 0; i < n; i++) begin
      pick = $urandom_range(99);
      if (pick < 12) k = K_CREATE;
      else if (pick < 16) k = K_CLOSE;
      else if (pick < 24) k = K_NOTIFY_ONE;
      else if (pick < 29) k = K_NOTIFY_ALL;
      else if (pick < 50) k = K_WAIT_BEGIN;
      else if (pick < 72) k = K_POLL;
      else if (pick < 80) k = K_CANCEL;
      else if (pick < 88) k = K_COUNT;
      else if (pick < 90) k = K_RESET_ALL;
      else k = 4'($urandom_range(15));
      s = 8'($urandom_range(NSLOT - 1));
      g = gen_q[s];
      w = 8'($urandom_range(NWAIT - 1));
      if ($urandom_range(9) == 0) s = 8'($urandom_range(255));
      if ($urandom_range(9) == 0) g = 16'($urandom_range(65535));
      if ($urandom_range(14) == 0) w = 8'($urandom_range(255));
      send_word(k, s, g, w, $urandom_range(5) == 0);
    end
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_kind = '0;
    in_slot_index = '0;
    in_handle_generation = '0;
    in_waiter_index = '0;
    in_cancelled = 1'b0;
    out_stall = 1'b0;
    errors = 0;
    words_sent = 0;
    words_checked = 0;
    cycles = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    for (int i = 0; i < NSLOT; i++) begin
      wipe_slot(i);
      gen_q[i] = '0;
    end
    hwm_q = 0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    send_idle_pct = 0;   recv_stall_pct = 0;  test_random(500);
    send_idle_pct = 63;  recv_stall_pct = 0;  test_random(500);
    send_idle_pct = 0;   recv_stall_pct = 63; test_random(500);
    send_idle_pct = 29;  recv_stall_pct = 29; test_random(500);
    drain();

    $display("covered %0d request words, %0d results checked, all kinds and idle mixes",
             words_sent, words_checked);
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end
endmodule
